[hw/rtl/tvcr_pkg.sv]
// shared types, sizes and codes of the tipsify vertex cache reorder block
`default_nettype none
package tvcr_pkg;

  localparam int MAX_VERTICES   = 1024;
  localparam int MAX_TRIANGLES  = 2048;
  localparam int DEAD_END_DEPTH = 128;
  localparam int MAX_USES       = 255;

  localparam int VIDX_W    = $clog2(MAX_VERTICES);
  localparam int TIDX_W    = $clog2(MAX_TRIANGLES);
  localparam int TCNT_W    = TIDX_W + 1;
  localparam int DE_W      = $clog2(DEAD_END_DEPTH);
  localparam int USE_W     = $clog2(MAX_USES + 1);
  localparam int ADJ_DEPTH = 3 * MAX_TRIANGLES;
  localparam int ADJ_W     = $clog2(ADJ_DEPTH + 1);
  localparam int K_W       = 7;
  localparam int STAMP_W   = $clog2(ADJ_DEPTH + (1 << K_W) + 1);
  localparam int CAND_DEPTH = 3 * MAX_USES;
  localparam int CAND_W    = $clog2(CAND_DEPTH + 1);
  localparam int VC_W      = 11;
  localparam int CFG_W     = 11;
  localparam int TRI_W     = 3 * VIDX_W;
  localparam int CQ_DEPTH  = 2;
  localparam int RQ_DEPTH  = 4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_USES  = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic CFG_CACHE_SIZE   = 1'b0;
  localparam logic CFG_VERTEX_COUNT = 1'b1;

  localparam logic [K_W-1:0]  CACHE_SIZE_RESET   = 7'd16;
  localparam logic [VC_W-1:0] VERTEX_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic              is_read;
    logic [VIDX_W-1:0] va;
    logic [VIDX_W-1:0] vb;
    logic [VIDX_W-1:0] vc;
    logic              last;
    logic              idx_bad;
    logic [K_W-1:0]    k;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [VIDX_W-1:0] va;
    logic [VIDX_W-1:0] vb;
    logic [VIDX_W-1:0] vc;
    logic              last;
  } res_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } eng_ctl_t;

  function automatic logic [VIDX_W-1:0] tri_vtx(input logic [TRI_W-1:0] word,
                                                input logic [1:0] idx);
    logic [VIDX_W-1:0] v;
    case (idx)
      2'd0: v = word[VIDX_W-1:0];
      2'd1: v = word[2*VIDX_W-1:VIDX_W];
      default: v = word[3*VIDX_W-1:2*VIDX_W];
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/tvcr_front.sv]
// front end: config registers, request classification and command queue
`default_nettype none
module tvcr_front import tvcr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              action,
  input  wire logic [VIDX_W-1:0] vertex_a,
  input  wire logic [VIDX_W-1:0] vertex_b,
  input  wire logic [VIDX_W-1:0] vertex_c,
  input  wire logic              last,
  input  wire logic              cfg_en,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire eng_ctl_t          ctl,
  output logic                   cmd_valid,
  output cmd_t                   cmd
);

  localparam int PTR_W = $clog2(CQ_DEPTH);
  localparam int CNT_W = $clog2(CQ_DEPTH + 1);

  logic [K_W-1:0]  cache_size;
  logic [VC_W-1:0] vertex_count;
  cmd_t            q [CQ_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic            accept;
  logic            take;
  cmd_t            entry;

  assign full      = (count == CNT_W'(CQ_DEPTH)) || ctl.clearing;
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign take      = ctl.pop && cmd_valid;
  assign cmd       = q[rp];

  always_comb begin
    entry.is_read = (action == ACT_READ);
    entry.va      = vertex_a;
    entry.vb      = vertex_b;
    entry.vc      = vertex_c;
    entry.last    = last;
    entry.idx_bad = ({1'b0, vertex_a} >= vertex_count) || ({1'b0, vertex_b} >= vertex_count)
                    || ({1'b0, vertex_c} >= vertex_count);
    entry.k       = cache_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_size   <= CACHE_SIZE_RESET;
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_CACHE_SIZE:   cache_size <= cfg_data[K_W-1:0];
        CFG_VERTEX_COUNT: vertex_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      count <= count + CNT_W'(accept) - CNT_W'(take);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tvcr_engine.sv]
// back end: mesh load, adjacency build, fan walk and reordered reads
`default_nettype none
module tvcr_engine import tvcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output eng_ctl_t  ctl,
  input  wire logic rq_full,
  output logic      rq_push,
  output res_t      res
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [30:0] {
    S_CLR  = 31'h0000_0001,
    S_IDLE = 31'h0000_0002,
    S_RD1  = 31'h0000_0004,
    S_RD2  = 31'h0000_0008,
    S_RD3  = 31'h0000_0010,
    S_LRA  = 31'h0000_0020,
    S_LRB  = 31'h0000_0040,
    S_LRC  = 31'h0000_0080,
    S_LCHK = 31'h0000_0100,
    S_LWR  = 31'h0000_0200,
    S_RESP = 31'h0000_0400,
    S_PFX  = 31'h0000_0800,
    S_FT1  = 31'h0000_1000,
    S_FT2  = 31'h0000_2000,
    S_FV1  = 31'h0000_4000,
    S_FV2  = 31'h0000_8000,
    S_FAN1 = 31'h0001_0000,
    S_FAN2 = 31'h0002_0000,
    S_ADJ1 = 31'h0004_0000,
    S_ADJ2 = 31'h0008_0000,
    S_TRI  = 31'h0010_0000,
    S_VTX1 = 31'h0020_0000,
    S_VTX2 = 31'h0040_0000,
    S_SC1  = 31'h0080_0000,
    S_SC2  = 31'h0100_0000,
    S_SC3  = 31'h0200_0000,
    S_DE1  = 31'h0400_0000,
    S_DE2  = 31'h0800_0000,
    S_DE3  = 31'h1000_0000,
    S_SW1  = 31'h2000_0000,
    S_SW2  = 31'h4000_0000
  } state_t;

  // memories
  logic [USE_W-1:0]   live_mem  [MAX_VERTICES];
  logic [STAMP_W-1:0] stamp_mem [MAX_VERTICES];
  logic [ADJ_W-1:0]   off_mem   [MAX_VERTICES];
  logic [USE_W-1:0]   fill_mem  [MAX_VERTICES];
  logic [TIDX_W-1:0]  adj_mem   [ADJ_DEPTH];
  logic [TRI_W-1:0]   tri_mem   [MAX_TRIANGLES];
  logic               emit_mem  [MAX_TRIANGLES];
  logic [TIDX_W-1:0]  ord_mem   [MAX_TRIANGLES];
  logic [VIDX_W-1:0]  ring_mem  [DEAD_END_DEPTH];
  logic [VIDX_W-1:0]  cand_mem  [CAND_DEPTH];

  logic [USE_W-1:0]   live_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [ADJ_W-1:0]   off_q;
  logic [USE_W-1:0]   fill_q;
  logic [TIDX_W-1:0]  adj_q;
  logic [TRI_W-1:0]   tri_q;
  logic               emit_q;
  logic [TIDX_W-1:0]  ord_q;
  logic [VIDX_W-1:0]  ring_q;
  logic [VIDX_W-1:0]  cand_q;

  // memory ports
  logic [VIDX_W-1:0]  vaddr;
  logic [TIDX_W-1:0]  tri_raddr;
  logic [DE_W-1:0]    ring_raddr;
  logic               live_we;
  logic [VIDX_W-1:0]  live_waddr;
  logic [USE_W-1:0]   live_wdata;
  logic               stamp_we;
  logic [VIDX_W-1:0]  stamp_waddr;
  logic [STAMP_W-1:0] stamp_wdata;
  logic               off_we;
  logic               fill_we;
  logic [VIDX_W-1:0]  fill_waddr;
  logic [USE_W-1:0]   fill_wdata;
  logic               emit_we;
  logic [TIDX_W-1:0]  emit_waddr;
  logic               emit_wdata;
  logic               tri_we;
  logic               ord_we;
  logic               adj_we;
  logic [ADJ_W-1:0]   adj_waddr;
  logic               ring_we;
  logic               cand_we;

  // control and walk registers
  state_t             state;
  cmd_t               cur;
  logic [CNT_W-1:0]   cnt;
  logic               pfx_v;
  logic [VIDX_W-1:0]  pfx_idx;
  logic [ADJ_W-1:0]   sum;
  logic [TCNT_W-1:0]  total;
  logic [TCNT_W-1:0]  rp;
  logic [TCNT_W-1:0]  t;
  logic [TCNT_W-1:0]  pos;
  logic               reading;
  logic               walk_pend;
  logic [USE_W-1:0]   la;
  logic [USE_W-1:0]   lb;
  logic [3*USE_W-1:0] nl;
  logic [1:0]         corner;
  logic [TRI_W-1:0]   tv;
  logic [STAMP_W-1:0] ts;
  logic [DE_W-1:0]    top;
  logic [DE_W-1:0]    bottom;
  logic [VIDX_W-1:0]  cursor;
  logic [VIDX_W-1:0]  f;
  logic [ADJ_W-1:0]   a_ptr;
  logic [ADJ_W-1:0]   a_end;
  logic [TIDX_W-1:0]  tri_cur;
  logic [CAND_W-1:0]  cc;
  logic [CAND_W-1:0]  j;
  logic [VIDX_W-1:0]  v_cur;
  logic [VIDX_W-1:0]  best;
  logic [STAMP_W-1:0] prio;
  logic               found;

  // datapath
  logic [VIDX_W-1:0]  w;
  logic [TRI_W-1:0]   cur_word;
  logic [STAMP_W-1:0] age;
  logic               stale;
  logic [STAMP_W:0]   sc_sum;
  logic [STAMP_W-1:0] score;
  logic               eq_ab;
  logic               eq_ac;
  logic               eq_bc;
  logic [USE_W:0]     na;
  logic [USE_W:0]     nb;
  logic [USE_W:0]     nc;
  logic               uses_bad;

  assign w        = tri_vtx(tv, corner);
  assign cur_word = {cur.vc, cur.vb, cur.va};
  assign age      = ts - stamp_q;
  assign stale    = age > STAMP_W'(cur.k);
  assign sc_sum   = {1'b0, age} + (STAMP_W + 1)'({live_q, 1'b0});
  assign score    = (sc_sum <= (STAMP_W + 1)'(cur.k)) ? age : '0;
  assign eq_ab    = (cur.va == cur.vb);
  assign eq_ac    = (cur.va == cur.vc);
  assign eq_bc    = (cur.vb == cur.vc);
  assign na       = {1'b0, la} + (USE_W + 1)'(eq_ab) + (USE_W + 1)'(eq_ac) + 1'b1;
  assign nb       = {1'b0, lb} + (USE_W + 1)'(eq_ab) + (USE_W + 1)'(eq_bc) + 1'b1;
  assign nc       = {1'b0, live_q} + (USE_W + 1)'(eq_ac) + (USE_W + 1)'(eq_bc) + 1'b1;
  assign uses_bad = (na > (USE_W + 1)'(MAX_USES)) || (nb > (USE_W + 1)'(MAX_USES))
                    || (nc > (USE_W + 1)'(MAX_USES));
  assign ring_raddr = top - 1'b1;

  assign ctl.pop      = (state == S_IDLE);
  assign ctl.clearing = (state == S_CLR);
  assign rq_push      = (state == S_RESP) && !rq_full;

  always_comb begin
    vaddr       = '0;
    tri_raddr   = '0;
    live_we     = 1'b0;
    live_waddr  = '0;
    live_wdata  = '0;
    stamp_we    = 1'b0;
    stamp_waddr = '0;
    stamp_wdata = '0;
    off_we      = 1'b0;
    fill_we     = 1'b0;
    fill_waddr  = '0;
    fill_wdata  = '0;
    emit_we     = 1'b0;
    emit_waddr  = '0;
    emit_wdata  = 1'b0;
    tri_we      = 1'b0;
    ord_we      = 1'b0;
    adj_we      = 1'b0;
    adj_waddr   = '0;
    ring_we     = 1'b0;
    cand_we     = 1'b0;
    case (state)
      S_CLR: begin
        live_we    = 1'b1;
        live_waddr = cnt[VIDX_W-1:0];
      end
      S_LRA: vaddr = cur.va;
      S_LRB: vaddr = cur.vb;
      S_LRC: vaddr = cur.vc;
      S_LCHK: tri_we = !uses_bad;
      S_LWR: begin
        live_we    = 1'b1;
        live_waddr = tri_vtx(cur_word, corner);
        case (corner)
          2'd0: live_wdata = nl[USE_W-1:0];
          2'd1: live_wdata = nl[2*USE_W-1:USE_W];
          default: live_wdata = nl[3*USE_W-1:2*USE_W];
        endcase
      end
      S_RD2: tri_raddr = ord_q;
      S_PFX: begin
        vaddr       = cnt[VIDX_W-1:0];
        off_we      = pfx_v;
        fill_we     = pfx_v;
        fill_waddr  = pfx_idx;
        stamp_we    = pfx_v;
        stamp_waddr = pfx_idx;
      end
      S_FT1: begin
        tri_raddr  = t[TIDX_W-1:0];
        emit_we    = (t != total);
        emit_waddr = t[TIDX_W-1:0];
      end
      S_FV1: vaddr = w;
      S_FV2: begin
        adj_we     = 1'b1;
        adj_waddr  = off_q + ADJ_W'(fill_q);
        fill_we    = 1'b1;
        fill_waddr = w;
        fill_wdata = fill_q + 1'b1;
      end
      S_FAN1: vaddr = f;
      S_ADJ2: tri_raddr = adj_q;
      S_TRI: begin
        ord_we     = !emit_q;
        emit_we    = !emit_q;
        emit_waddr = tri_cur;
        emit_wdata = 1'b1;
      end
      S_VTX1: begin
        vaddr   = w;
        ring_we = 1'b1;
        cand_we = 1'b1;
      end
      S_VTX2: begin
        live_we     = (live_q != '0);
        live_waddr  = w;
        live_wdata  = live_q - 1'b1;
        stamp_we    = stale;
        stamp_waddr = w;
        stamp_wdata = ts;
      end
      S_SC2: vaddr = cand_q;
      S_DE2: vaddr = ring_q;
      S_SW1: vaddr = cursor + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    live_q  <= live_mem[vaddr];
    stamp_q <= stamp_mem[vaddr];
    off_q   <= off_mem[vaddr];
    fill_q  <= fill_mem[vaddr];
    adj_q   <= adj_mem[a_ptr];
    tri_q   <= tri_mem[tri_raddr];
    emit_q  <= emit_mem[adj_q];
    ord_q   <= ord_mem[rp[TIDX_W-1:0]];
    ring_q  <= ring_mem[ring_raddr];
    cand_q  <= cand_mem[j];
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    if (off_we) begin
      off_mem[pfx_idx] <= sum;
    end
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (adj_we) begin
      adj_mem[adj_waddr] <= t[TIDX_W-1:0];
    end
    if (tri_we) begin
      tri_mem[total[TIDX_W-1:0]] <= cur_word;
    end
    if (emit_we) begin
      emit_mem[emit_waddr] <= emit_wdata;
    end
    if (ord_we) begin
      ord_mem[pos[TIDX_W-1:0]] <= tri_cur;
    end
    if (ring_we) begin
      ring_mem[top] <= w;
    end
    if (cand_we) begin
      cand_mem[cc] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      reading   <= 1'b0;
      total     <= '0;
      rp        <= '0;
      walk_pend <= 1'b0;
      pfx_v     <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_VERTICES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            res <= '0;
            if (cmd.is_read) begin
              walk_pend <= 1'b0;
              if (!reading || rp >= total) begin
                res.status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                state <= S_RD1;
              end
            end else begin
              walk_pend <= cmd.last;
              if (reading) begin
                reading <= 1'b0;
                total   <= '0;
                rp      <= '0;
              end
              if (cmd.idx_bad) begin
                res.status <= ST_INDEX;
                state      <= S_RESP;
              end else if (!reading && total >= TCNT_W'(MAX_TRIANGLES)) begin
                res.status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                state <= S_LRA;
              end
            end
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_RD3;
        S_RD3: begin
          res.status <= ST_OK;
          res.va     <= tri_vtx(tri_q, 2'd0);
          res.vb     <= tri_vtx(tri_q, 2'd1);
          res.vc     <= tri_vtx(tri_q, 2'd2);
          res.last   <= (rp + 1'b1 == total);
          rp         <= rp + 1'b1;
          state      <= S_RESP;
        end
        S_LRA: state <= S_LRB;
        S_LRB: begin
          la    <= live_q;
          state <= S_LRC;
        end
        S_LRC: begin
          lb    <= live_q;
          state <= S_LCHK;
        end
        S_LCHK: begin
          if (uses_bad) begin
            res.status <= ST_USES;
            state      <= S_RESP;
          end else begin
            nl     <= {nc[USE_W-1:0], nb[USE_W-1:0], na[USE_W-1:0]};
            total  <= total + 1'b1;
            corner <= 2'd0;
            state  <= S_LWR;
          end
        end
        S_LWR: begin
          if (corner == 2'd2) begin
            res.status <= ST_OK;
            state      <= S_RESP;
          end else begin
            corner <= corner + 1'b1;
          end
        end
        S_RESP: begin
          if (!rq_full) begin
            if (walk_pend) begin
              cnt   <= '0;
              sum   <= '0;
              pfx_v <= 1'b0;
              state <= S_PFX;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PFX: begin
          if (cnt != CNT_W'(MAX_VERTICES)) begin
            cnt <= cnt + 1'b1;
          end
          pfx_v   <= (cnt != CNT_W'(MAX_VERTICES));
          pfx_idx <= cnt[VIDX_W-1:0];
          if (pfx_v) begin
            sum <= sum + ADJ_W'(live_q);
          end
          if (cnt == CNT_W'(MAX_VERTICES) && !pfx_v) begin
            t     <= '0;
            state <= S_FT1;
          end
        end
        S_FT1: begin
          if (t == total) begin
            ts     <= STAMP_W'(cur.k) + 1'b1;
            top    <= '0;
            bottom <= '0;
            cursor <= '0;
            pos    <= '0;
            f      <= '0;
            state  <= S_FAN1;
          end else begin
            state <= S_FT2;
          end
        end
        S_FT2: begin
          tv     <= tri_q;
          corner <= 2'd0;
          state  <= S_FV1;
        end
        S_FV1: state <= S_FV2;
        S_FV2: begin
          if (corner == 2'd2) begin
            t     <= t + 1'b1;
            state <= S_FT1;
          end else begin
            corner <= corner + 1'b1;
            state  <= S_FV1;
          end
        end
        S_FAN1: state <= S_FAN2;
        S_FAN2: begin
          a_ptr <= off_q;
          a_end <= off_q + ADJ_W'(fill_q);
          cc    <= '0;
          state <= S_ADJ1;
        end
        S_ADJ1: begin
          if (a_ptr == a_end) begin
            j     <= '0;
            found <= 1'b0;
            prio  <= '0;
            state <= S_SC1;
          end else begin
            state <= S_ADJ2;
          end
        end
        S_ADJ2: begin
          tri_cur <= adj_q;
          state   <= S_TRI;
        end
        S_TRI: begin
          if (emit_q) begin
            a_ptr <= a_ptr + 1'b1;
            state <= S_ADJ1;
          end else begin
            pos    <= pos + 1'b1;
            tv     <= tri_q;
            corner <= 2'd0;
            state  <= S_VTX1;
          end
        end
        S_VTX1: begin
          top <= top + 1'b1;
          if (DE_W'(top + 1'b1) == bottom) begin
            bottom <= bottom + 1'b1;
          end
          cc    <= cc + 1'b1;
          state <= S_VTX2;
        end
        S_VTX2: begin
          if (stale) begin
            ts <= ts + 1'b1;
          end
          if (corner == 2'd2) begin
            a_ptr <= a_ptr + 1'b1;
            state <= S_ADJ1;
          end else begin
            corner <= corner + 1'b1;
            state  <= S_VTX1;
          end
        end
        S_SC1: begin
          if (j == cc) begin
            if (found) begin
              f     <= best;
              state <= S_FAN1;
            end else begin
              state <= S_DE1;
            end
          end else begin
            state <= S_SC2;
          end
        end
        S_SC2: begin
          v_cur <= cand_q;
          state <= S_SC3;
        end
        S_SC3: begin
          if (live_q != '0 && (!found || score > prio)) begin
            found <= 1'b1;
            prio  <= score;
            best  <= v_cur;
          end
          j     <= j + 1'b1;
          state <= S_SC1;
        end
        S_DE1: begin
          if (top == bottom) begin
            state <= S_SW1;
          end else begin
            top   <= top - 1'b1;
            state <= S_DE2;
          end
        end
        S_DE2: begin
          v_cur <= ring_q;
          state <= S_DE3;
        end
        S_DE3: begin
          if (live_q != '0) begin
            f     <= v_cur;
            state <= S_FAN1;
          end else begin
            state <= S_DE1;
          end
        end
        S_SW1: begin
          if (cursor == '1) begin
            reading <= 1'b1;
            rp      <= '0;
            state   <= S_IDLE;
          end else begin
            cursor <= cursor + 1'b1;
            state  <= S_SW2;
          end
        end
        S_SW2: begin
          if (live_q != '0) begin
            f     <= cursor;
            state <= S_FAN1;
          end else begin
            state <= S_SW1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tvcr_rq.sv]
// result queue between the engine and the result ports
`default_nettype none
module tvcr_rq import tvcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t res_in,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output res_t      head
);

  localparam int PTR_W = $clog2(RQ_DEPTH);
  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  res_t             q [RQ_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic             put;
  logic             take;

  assign full  = (count == CNT_W'(RQ_DEPTH));
  assign empty = (count == '0);
  assign put   = push && !full;
  assign take  = pop && !empty;
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (put) begin
      q[wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (put) begin
        wp <= wp + 1'b1;
      end
      if (take) begin
        rp <= rp + 1'b1;
      end
      count <= count + CNT_W'(put) - CNT_W'(take);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tipsify_vertex_cache_reorder_top.sv]
// top level of the tipsify vertex cache reorder block
//
//   channel   handshake      payload
//   request   push / full    action, vertex_a, vertex_b, vertex_c, last
//   result    pop / empty    status, out_vertex_a, out_vertex_b, out_vertex_c, last_out
//   config    cfg_en         cfg_index, cfg_data
//
// a load passes the engine states LRA, LRB, LRC, LCHK, LWR and RESP, a read RD1, RD2, RD3
// and RESP, set by one port per vertex memory; a load with last adds the walk: a prefix
// sum over all vertices, the adjacency build per triangle, the fans per corner and
// per candidate, and a sweep over the vertex indices
// after reset a clearing pass over all 1024 vertices zeroes the use counts; full stays high
// a 2-entry command queue and a 4-entry result queue let either side stall alone
`default_nettype none
module tipsify_vertex_cache_reorder_top import tvcr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              action,
  input  wire logic [VIDX_W-1:0] vertex_a,
  input  wire logic [VIDX_W-1:0] vertex_b,
  input  wire logic [VIDX_W-1:0] vertex_c,
  input  wire logic              last,
  output logic                   empty,
  input  wire logic              pop,
  output logic [1:0]             status,
  output logic [VIDX_W-1:0]      out_vertex_a,
  output logic [VIDX_W-1:0]      out_vertex_b,
  output logic [VIDX_W-1:0]      out_vertex_c,
  output logic                   last_out,
  input  wire logic              cfg_en,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  eng_ctl_t ctl;
  cmd_t     cmd;
  logic     cmd_valid;
  logic     rq_full;
  logic     rq_push;
  res_t     res;
  res_t     head;

  tvcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .vertex_a  (vertex_a),
    .vertex_b  (vertex_b),
    .vertex_c  (vertex_c),
    .last      (last),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  tvcr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctl       (ctl),
    .rq_full   (rq_full),
    .rq_push   (rq_push),
    .res       (res)
  );

  tvcr_rq u_rq (
    .clk    (clk),
    .rst    (rst),
    .push   (rq_push),
    .res_in (res),
    .full   (rq_full),
    .pop    (pop),
    .empty  (empty),
    .head   (head)
  );

  assign status       = head.status;
  assign out_vertex_a = head.va;
  assign out_vertex_b = head.vb;
  assign out_vertex_c = head.vc;
  assign last_out     = head.last;

endmodule
`default_nettype wire

[bench/tipsify_vertex_cache_reorder_top_tb.sv]
// self-checking testbench of the tipsify vertex cache reorder block
`default_nettype none
module tipsify_vertex_cache_reorder_top_tb;
  import tvcr_pkg::*;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic              action;
  logic [VIDX_W-1:0] vertex_a;
  logic [VIDX_W-1:0] vertex_b;
  logic [VIDX_W-1:0] vertex_c;
  logic              last;
  logic              empty;
  logic              pop;
  logic [1:0]        status;
  logic [VIDX_W-1:0] out_vertex_a;
  logic [VIDX_W-1:0] out_vertex_b;
  logic [VIDX_W-1:0] out_vertex_c;
  logic              last_out;
  logic              cfg_en;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  tipsify_vertex_cache_reorder_top u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mirror of the mesh and walk state
  logic [VIDX_W-1:0] m_tri[MAX_TRIANGLES][3];
  int m_live[MAX_VERTICES];
  int m_adj_off[MAX_VERTICES+1];
  int m_adj[ADJ_DEPTH];
  int m_fill[MAX_VERTICES];
  int m_stamp[MAX_VERTICES];
  bit m_done[MAX_TRIANGLES];
  int m_ring[DEAD_END_DEPTH];
  int m_top, m_bot;
  int m_cand[CAND_DEPTH];
  int m_ncand;
  int m_clock;
  int m_cursor;
  int m_order[MAX_TRIANGLES];
  int m_total, m_rd;
  bit m_reading;
  int m_k, m_vcount;

  res_t tri_q[$];
  int   errors;
  int   n_items;
  int   n_results;
  bit   tx_busy, rx_busy;
  int   pop_wait;

  function automatic void clear_mesh();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m_live[i] = 0;
      m_stamp[i] = 0;
    end
    for (int i = 0; i < MAX_TRIANGLES; i++) m_done[i] = 0;
    for (int i = 0; i < DEAD_END_DEPTH; i++) m_ring[i] = 0;
    m_top = 0;
    m_bot = 0;
    m_ncand = 0;
    m_cursor = 0;
    m_total = 0;
    m_rd = 0;
    m_reading = 0;
    m_clock = m_k + 1;
  endfunction

  function automatic int pop_dead_end();
    int d;
    while (m_top != m_bot) begin
      m_top = (m_top + DEAD_END_DEPTH - 1) % DEAD_END_DEPTH;
      d = m_ring[m_top];
      if (m_live[d] > 0) return d;
    end
    while (m_cursor + 1 < MAX_VERTICES) begin
      m_cursor++;
      if (m_live[m_cursor] > 0) return m_cursor;
    end
    return -1;
  endfunction

  function automatic int pick_fan_vertex();
    int best, prio, v, p, age;
    best = -1;
    prio = -1;
    for (int j = 0; j < m_ncand; j++) begin
      v = m_cand[j];
      if (m_live[v] > 0) begin
        p = 0;
        age = m_clock - m_stamp[v];
        if (age + 2 * m_live[v] <= m_k) p = age;
        if (p > prio) begin
          prio = p;
          best = v;
        end
      end
    end
    if (best < 0) best = pop_dead_end();
    return best;
  endfunction

  function automatic void reorder_mesh();
    int sum, pos, f, w, a, tr;
    sum = 0;
    pos = 0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      m_adj_off[v] = sum;
      sum += m_live[v];
      m_fill[v] = 0;
    end
    m_adj_off[MAX_VERTICES] = sum;
    for (int t = 0; t < m_total; t++)
      for (int c = 0; c < 3; c++) begin
        w = m_tri[t][c];
        a = m_adj_off[w] + m_fill[w];
        if (a < ADJ_DEPTH) m_adj[a] = t;
        m_fill[w]++;
      end
    for (int i = 0; i < MAX_VERTICES; i++) m_stamp[i] = 0;
    for (int i = 0; i < MAX_TRIANGLES; i++) m_done[i] = 0;
    for (int i = 0; i < DEAD_END_DEPTH; i++) m_ring[i] = 0;
    m_top = 0;
    m_bot = 0;
    m_cursor = 0;
    m_clock = m_k + 1;
    f = 0;
    while (f >= 0) begin
      m_ncand = 0;
      for (a = m_adj_off[f]; a < m_adj_off[f+1] && a < ADJ_DEPTH; a++) begin
        tr = m_adj[a];
        if (tr >= m_total || m_done[tr]) continue;
        if (pos < MAX_TRIANGLES) begin
          m_order[pos] = tr;
          pos++;
        end
        for (int c = 0; c < 3; c++) begin
          w = m_tri[tr][c];
          m_ring[m_top] = w;
          m_top = (m_top + 1) % DEAD_END_DEPTH;
          if (m_top == m_bot) m_bot = (m_bot + 1) % DEAD_END_DEPTH;
          if (m_ncand < CAND_DEPTH) begin
            m_cand[m_ncand] = w;
            m_ncand++;
          end
          if (m_live[w] > 0) m_live[w]--;
          if (m_clock - m_stamp[w] > m_k) begin
            m_stamp[w] = m_clock;
            m_clock++;
          end
        end
        m_done[tr] = 1;
      end
      f = pick_fan_vertex();
    end
    m_rd = 0;
    m_reading = 1;
  endfunction

  function automatic res_t predict_triangle(input logic act, input logic [VIDX_W-1:0] a,
                                            input logic [VIDX_W-1:0] b,
                                            input logic [VIDX_W-1:0] c, input logic lst);
    res_t r;
    int vx[3];
    int n, t;
    r = '0;
    if (act == ACT_READ) begin
      if (!m_reading || m_rd >= m_total) begin
        r.status = ST_FULL;
        return r;
      end
      t = m_order[m_rd];
      r.va = m_tri[t][0];
      r.vb = m_tri[t][1];
      r.vc = m_tri[t][2];
      r.last = (m_rd + 1 == m_total);
      m_rd++;
      return r;
    end
    if (m_reading) clear_mesh();
    vx[0] = a;
    vx[1] = b;
    vx[2] = c;
    r.status = ST_OK;
    for (int i = 0; i < 3; i++)
      if (vx[i] >= m_vcount) r.status = ST_INDEX;
    if (r.status == ST_OK && m_total >= MAX_TRIANGLES) r.status = ST_FULL;
    if (r.status == ST_OK)
      for (int i = 0; i < 3; i++) begin
        n = m_live[vx[i]] + (vx[0] == vx[i]) + (vx[1] == vx[i]) + (vx[2] == vx[i]);
        if (n > MAX_USES) r.status = ST_USES;
      end
    if (r.status == ST_OK) begin
      for (int i = 0; i < 3; i++) begin
        m_tri[m_total][i] = vx[i];
        m_live[vx[i]]++;
      end
      m_total++;
    end
    if (lst) reorder_mesh();
    return r;
  endfunction

  task automatic send_request(input logic act, input logic [VIDX_W-1:0] a,
                              input logic [VIDX_W-1:0] b, input logic [VIDX_W-1:0] c,
                              input logic lst, input bit typed, input res_t want);
    int   gap;
    res_t p;
    gap = tx_busy ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    action   <= act;
    vertex_a <= a;
    vertex_b <= b;
    vertex_c <= c;
    last     <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    p = predict_triangle(act, a, b, c, lst);
    tri_q.push_back(typed ? want : p);
    n_items++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_en <= 1'b0;
    if (idx == CFG_CACHE_SIZE) m_k = data[K_W-1:0];
    else m_vcount = data;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (tri_q.size() != 0) @(posedge clk);
    repeat (2000 + 40 * m_total) @(posedge clk);
  endtask

  task automatic random_mesh(input int n, input int span, input int noise);
    logic [VIDX_W-1:0] a, b, c;
    int reads;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise) begin
        if ($urandom_range(0, 3) == 0)
          send_request(ACT_READ, $urandom, $urandom, $urandom, $urandom, 0, '0);
        else
          send_request(ACT_LOAD, $urandom, $urandom, $urandom, i == n - 1, 0, '0);
      end else begin
        a = $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
        c = $urandom_range(0, span - 1);
        send_request(ACT_LOAD, a, b, c, i == n - 1, 0, '0);
      end
    end
    reads = m_total + $urandom_range(0, 2);
    if (reads > 40) reads = 40 + $urandom_range(0, 2);
    for (int i = 0; i < reads; i++)
      send_request(ACT_READ, $urandom, $urandom, $urandom, $urandom, 0, '0);
  endtask

  // directed rows
  typedef struct {
    logic              act;
    logic [VIDX_W-1:0] a, b, c;
    logic              lst;
    bit                typed;
    res_t              want;
  } row_t;

  localparam res_t R_OK    = '{status: ST_OK, default: '0};
  localparam res_t R_EMPTY = '{status: ST_FULL, default: '0};
  localparam res_t R_INDEX = '{status: ST_INDEX, default: '0};

  row_t rows_a[] = '{
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 1, R_EMPTY},
    '{ACT_LOAD, 10'd0, 10'd1, 10'd2, 1'b0, 1, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 1, R_EMPTY},
    '{ACT_LOAD, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1, R_OK},
    '{ACT_LOAD, 10'd1023, 10'd2, 10'd5, 1'b0, 1, R_OK},
    '{ACT_LOAD, 10'd5, 10'd5, 10'd0, 1'b0, 1, R_OK},
    '{ACT_LOAD, 10'd3, 10'd4, 10'd1023, 1'b1, 1, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 0, R_OK},
    '{ACT_READ, 10'd1023, 10'd1023, 10'd1023, 1'b1, 0, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 0, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 0, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 0, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 1, R_EMPTY}
  };

  row_t rows_b[] = '{
    '{ACT_LOAD, 10'd7, 10'd8, 10'd9, 1'b0, 1, R_OK},
    '{ACT_LOAD, 10'd999, 10'd0, 10'd0, 1'b0, 1, R_OK},
    '{ACT_LOAD, 10'd1000, 10'd0, 10'd0, 1'b0, 1, R_INDEX},
    '{ACT_LOAD, 10'd0, 10'd0, 10'd1023, 1'b0, 1, R_INDEX},
    '{ACT_LOAD, 10'd1, 10'd1000, 10'd1, 1'b1, 1, R_INDEX},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 0, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 0, R_OK},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 1, R_EMPTY},
    '{ACT_LOAD, 10'd1020, 10'd0, 10'd0, 1'b1, 1, R_INDEX},
    '{ACT_READ, 10'd0, 10'd0, 10'd0, 1'b0, 1, R_EMPTY}
  };

  // result side: stall, long hold-off and compare
  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (tri_q.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          if (status !== tri_q[0].status) begin
            $error("status exp %0d got %0d", tri_q[0].status, status);
            errors++;
          end
          if (out_vertex_a !== tri_q[0].va) begin
            $error("out_vertex_a exp %0d got %0d", tri_q[0].va, out_vertex_a);
            errors++;
          end
          if (out_vertex_b !== tri_q[0].vb) begin
            $error("out_vertex_b exp %0d got %0d", tri_q[0].vb, out_vertex_b);
            errors++;
          end
          if (out_vertex_c !== tri_q[0].vc) begin
            $error("out_vertex_c exp %0d got %0d", tri_q[0].vc, out_vertex_c);
            errors++;
          end
          if (last_out !== tri_q[0].last) begin
            $error("last_out exp %0d got %0d", tri_q[0].last, last_out);
            errors++;
          end
          void'(tri_q.pop_front());
        end
        n_results++;
        pop_wait = rx_busy ? $urandom_range(0, 19) : 0;
        if (n_results == 40 || n_results == 900) pop_wait = 400;
      end else if (!pop && pop_wait > 0) begin
        pop_wait--;
      end
      pop <= (pop_wait == 0);
    end
  end

  initial begin
    #20_000_000;
    $display("[tipsify_vertex_cache_reorder_top] ERROR");
    $finish;
  end

  initial begin
    int vc, span, n;
    bit big_done;
    errors    = 0;
    n_items   = 0;
    n_results = 0;
    tx_busy   = 1;
    rx_busy   = 1;
    big_done  = 0;
    m_k       = CACHE_SIZE_RESET;
    m_vcount  = VERTEX_COUNT_RESET;
    clear_mesh();
    rst       <= 1'b1;
    push      <= 1'b0;
    action    <= ACT_LOAD;
    vertex_a  <= '0;
    vertex_b  <= '0;
    vertex_c  <= '0;
    last      <= 1'b0;
    cfg_en    <= 1'b0;
    cfg_index <= CFG_CACHE_SIZE;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows_a[i])
      send_request(rows_a[i].act, rows_a[i].a, rows_a[i].b, rows_a[i].c, rows_a[i].lst,
                   rows_a[i].typed, rows_a[i].want);
    drain();
    write_reg(CFG_VERTEX_COUNT, 11'd1000);
    write_reg(CFG_CACHE_SIZE, 11'd1);
    foreach (rows_b[i])
      send_request(rows_b[i].act, rows_b[i].a, rows_b[i].b, rows_b[i].c, rows_b[i].lst,
                   rows_b[i].typed, rows_b[i].want);

    for (int ph = 0; n_items < 1800; ph++) begin
      drain();
      tx_busy = $urandom_range(0, 3) != 0;
      rx_busy = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 4))
        0: write_reg(CFG_CACHE_SIZE, {4'($urandom), 7'd1});
        1: write_reg(CFG_CACHE_SIZE, {4'($urandom), 7'd64});
        2: write_reg(CFG_CACHE_SIZE, {4'($urandom), 7'($urandom_range(0, 1) ? 0 : 127)});
        default: write_reg(CFG_CACHE_SIZE, {4'($urandom), 7'($urandom_range(2, 40))});
      endcase
      if (ph == 3 && !big_done) begin
        // fill the triangle store past capacity
        big_done = 1;
        tx_busy = 0;
        rx_busy = 0;
        write_reg(CFG_VERTEX_COUNT, 11'd1024);
        random_mesh(MAX_TRIANGLES + 2, 1024, 0);
        continue;
      end
      case ($urandom_range(0, 5))
        0: vc = 1;
        1: vc = 1024;
        2: vc = 3;
        default: vc = $urandom_range(1, 1024);
      endcase
      write_reg(CFG_VERTEX_COUNT, 11'(vc));
      for (int m = $urandom_range(1, 4); m > 0; m--) begin
        case ($urandom_range(0, 3))
          0: span = 3;
          1: span = 8;
          2: span = 30;
          default: span = vc;
        endcase
        if (span > vc) span = vc;
        n = (vc == 1 && $urandom_range(0, 1)) ? 90 : $urandom_range(1, 40);
        random_mesh(n, span, 10);
      end
    end

    push <= 1'b0;
    while (tri_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[tipsify_vertex_cache_reorder_top] OK");
    end else begin
      $display("[tipsify_vertex_cache_reorder_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
